// ===== hdl/mlp_pkg.sv =====
// Package for the MLP classifier: item types, state codes, fixed-point
// constants and helper functions. No dependencies.
package mlp_pkg;

   localparam int MaxNodes   = 8;
   localparam int FracBits   = 12;
   localparam int HalfBits   = FracBits - 1;

   localparam logic [1:0] CMD_WEIGHT   = 2'd0;
   localparam logic [1:0] CMD_BIAS     = 2'd1;
   localparam logic [1:0] CMD_CLASSIFY = 2'd2;

   localparam logic [12:0] VALUE_ONE = 13'd4096;
   localparam logic [12:0] CONF_HALF = 13'd2048;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [1:0]         target_layer;
      logic [2:0]         target_node;
      logic [2:0]         source_node;
      logic signed [15:0] coefficient;
      logic [12:0]        first_value;
      logic [12:0]        second_value;
   } req_type;

   typedef struct packed {
      logic        first_greater;
      logic [12:0] confidence;
      logic        correct;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic mac;
      logic bias;
   } mac_ctrl_type;

   typedef enum logic [2:0] {
      S_IDLE, S_RD, S_MAC, S_BRD, S_BIAS, S_ACT, S_DONE
   } state_type;

   function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
      logic signed [15:0] r;
      if (v > 22'sd32767) r = 16'sh7fff;
      else if (v < -22'sd32768) r = 16'sh8000;
      else r = v[15:0];
      return r;
   endfunction

   // Sigmoid samples at 0, 0.5, ... 8.0 in Q0.12.
   function automatic logic [12:0] sig_tab(input logic [4:0] idx);
      logic [12:0] r;
      case (idx)
         5'd0:  r = 13'd2048;
         5'd1:  r = 13'd2550;
         5'd2:  r = 13'd2994;
         5'd3:  r = 13'd3349;
         5'd4:  r = 13'd3608;
         5'd5:  r = 13'd3785;
         5'd6:  r = 13'd3902;
         5'd7:  r = 13'd3976;
         5'd8:  r = 13'd4022;
         5'd9:  r = 13'd4051;
         5'd10: r = 13'd4069;
         5'd11: r = 13'd4079;
         5'd12: r = 13'd4086;
         5'd13: r = 13'd4090;
         5'd14: r = 13'd4092;
         5'd15: r = 13'd4094;
         default: r = 13'd4095;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] clamp_nodes(input logic [3:0] n);
      logic [3:0] r;
      if (n == 4'd0) r = 4'd1;
      else if (n > 4'(MaxNodes)) r = 4'(MaxNodes);
      else r = n;
      return r;
   endfunction

endpackage

// ===== hdl/mlp_mac.sv =====
// Shared multiply, round and saturating accumulate unit of the MLP classifier.
// Depends on mlp_pkg.
module mlp_mac import mlp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  mac_ctrl_type       ctrl,
   input  logic signed [15:0] weight,
   input  logic signed [15:0] act,
   input  logic signed [15:0] bias,
   output logic signed [15:0] acc
);
   logic signed [15:0] acc_ff, acc_in;
   logic signed [31:0] prod;
   logic signed [32:0] rnd_full;
   logic signed [21:0] addend;

   assign prod     = weight * act;
   // Round half up: add one half LSB, then floor by arithmetic shift.
   assign rnd_full = ($signed({prod[31], prod}) + 33'sd2048) >>> FracBits;

   always_comb begin
      addend = ctrl.bias ? 22'(bias) : rnd_full[21:0];
      acc_in = acc_ff;
      if (ctrl.clear) acc_in = '0;
      else if (ctrl.mac || ctrl.bias) acc_in = sat16(22'(acc_ff) + addend);
   end

   always_ff @(posedge clock) begin
      if (reset) acc_ff <= '0;
      else acc_ff <= acc_in;
   end

   assign acc = acc_ff;
endmodule

// ===== hdl/mlp_sigmoid.sv =====
// Table-interpolated sigmoid(x - 1) of the MLP classifier, Q4.12 in, Q0.12 out.
// Depends on mlp_pkg.
module mlp_sigmoid import mlp_pkg::*; (
   input  logic signed [15:0] x,
   output logic [12:0]        s
);
   logic signed [16:0] u;
   logic [16:0]        m;
   logic [5:0]         idx;
   logic [10:0]        pos;
   logic [12:0]        lo, hi, mag;
   logic [19:0]        prod;

   always_comb begin
      u    = 17'(x) - 17'sd4096;
      m    = u[16] ? 17'(-u) : 17'(u);
      idx  = m[16:HalfBits];
      pos  = m[HalfBits-1:0];
      lo   = sig_tab(idx[4:0]);
      hi   = sig_tab(idx[4:0] + 5'd1);
      prod = 9'(hi - lo) * pos;
      if (idx >= 6'd16) mag = 13'd4095;
      else mag = lo + 13'(prod >> HalfBits);
      s = u[16] ? (VALUE_ONE - mag) : mag;
   end
endmodule

// ===== hdl/mlp_forward_classifier.sv =====
// Top level of the MLP classifier: sequencer, weight, bias and activation
// memories, configuration registers and result register. Uses mlp_pkg,
// mlp_mac and mlp_sigmoid.

// A weight or bias write item gives no result. A classify item runs the whole
// network on the single shared multiply-accumulate unit: for each product it
// reads the weight and activation memories, then accumulates; for each node it
// then reads the bias, adds it and writes the activation, and at the end it
// loads the result register. The block takes no new item while a classify item
// is being worked; the result waits in an output register, so the next item may
// be accepted while it is still stalled. Hidden layers use ReLU and the last
// layer uses sigmoid(x - 1); the confidence is output node zero. Configuration
// must be written only while idle; the block itself does not enforce this.
// Weights and biases must be written before a classify item reads them.
module mlp_forward_classifier import mlp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [3:0] csr_wdata
);
   localparam logic [1:0] REG_LAYERS = 2'd0;
   localparam logic [1:0] REG_NODES1 = 2'd1;
   localparam logic [1:0] REG_NODES2 = 2'd2;
   localparam logic [1:0] REG_NODES3 = 2'd3;

   logic [2:0] layer_count_ff;
   logic [3:0] nodes1_ff, nodes2_ff, nodes3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_count_ff <= 3'd3;
         nodes1_ff      <= 4'd8;
         nodes2_ff      <= 4'd1;
         nodes3_ff      <= 4'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_LAYERS: layer_count_ff <= csr_wdata[2:0];
            REG_NODES1: nodes1_ff      <= csr_wdata;
            REG_NODES2: nodes2_ff      <= csr_wdata;
            REG_NODES3: nodes3_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer state.
   state_type   state_ff, state_in;
   logic [1:0]  layer_ff, layer_in;
   logic [1:0]  last_ff, last_in;
   logic [2:0]  node_ff, node_in;
   logic [2:0]  src_ff, src_in;
   logic [3:0]  prev_ff, prev_in;
   logic        bank_ff, bank_in;
   logic [12:0] a_ff, a_in, b_ff, b_in;
   logic [12:0] conf_ff, conf_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic              accept;
   logic [3:0]        size;
   logic [2:0]        lc_clamped;
   mac_ctrl_type      mac_ctrl;
   logic signed [15:0] acc, sig_x;
   logic [12:0]       sig_s;
   logic signed [15:0] w_rd_ff, a_rd_ff, b_rd_ff;
   logic              act_we;
   logic signed [15:0] act_wdata;

   logic signed [15:0] wmem [0:191];
   logic signed [15:0] bmem [0:23];
   logic signed [15:0] amem [0:15];

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      unique case (layer_ff)
         2'd0:    size = clamp_nodes(nodes1_ff);
         2'd1:    size = clamp_nodes(nodes2_ff);
         default: size = clamp_nodes(nodes3_ff);
      endcase
      if (layer_count_ff < 3'd2) lc_clamped = 3'd2;
      else if (layer_count_ff > 3'd4) lc_clamped = 3'd4;
      else lc_clamped = layer_count_ff;
   end

   // Weight and bias writes go straight into the memories from an accepted item.
   always_ff @(posedge clock) begin
      if (accept && req_data.cmd == CMD_WEIGHT && req_data.target_layer != 2'd0)
         wmem[{req_data.target_layer - 2'd1, req_data.target_node, req_data.source_node}]
            <= req_data.coefficient;
      w_rd_ff <= wmem[{layer_ff, node_ff, src_ff}];
   end

   always_ff @(posedge clock) begin
      if (accept && req_data.cmd == CMD_BIAS && req_data.target_layer != 2'd0)
         bmem[{req_data.target_layer - 2'd1, req_data.target_node}] <= req_data.coefficient;
      b_rd_ff <= bmem[{layer_ff, node_ff}];
   end

   // The first layer reads the two input values directly; later layers read
   // the bank written by the layer before.
   always_ff @(posedge clock) begin
      if (act_we) amem[{!bank_ff, node_ff}] <= act_wdata;
      if (layer_ff == 2'd0) a_rd_ff <= src_ff[0] ? 16'(b_ff) : 16'(a_ff);
      else a_rd_ff <= amem[{bank_ff, src_ff}];
   end

   mlp_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .weight (w_rd_ff),
      .act    (a_rd_ff),
      .bias   (b_rd_ff),
      .acc    (acc)
   );

   assign sig_x = acc;
   mlp_sigmoid u_sig (.x(sig_x), .s(sig_s));

   always_comb begin
      state_in     = state_ff;
      layer_in     = layer_ff;
      last_in      = last_ff;
      node_in      = node_ff;
      src_in       = src_ff;
      prev_in      = prev_ff;
      bank_in      = bank_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      conf_in      = conf_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mac_ctrl     = '0;
      act_we       = 1'b0;
      act_wdata    = acc[15] ? 16'sd0 : acc;

      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_data.cmd == CMD_CLASSIFY) begin
               a_in     = (req_data.first_value > VALUE_ONE) ? VALUE_ONE
                                                              : req_data.first_value;
               b_in     = (req_data.second_value > VALUE_ONE) ? VALUE_ONE
                                                               : req_data.second_value;
               last_in  = 2'(lc_clamped - 3'd2);
               layer_in = 2'd0;
               node_in  = '0;
               src_in   = '0;
               prev_in  = 4'd2;
               bank_in  = 1'b0;
               conf_in  = CONF_HALF;
               mac_ctrl.clear = 1'b1;
               state_in = S_RD;
            end
         end
         S_RD: state_in = S_MAC;
         S_MAC: begin
            mac_ctrl.mac = 1'b1;
            if ({1'b0, src_ff} == prev_ff - 4'd1) state_in = S_BRD;
            else begin
               src_in   = src_ff + 3'd1;
               state_in = S_RD;
            end
         end
         S_BRD: state_in = S_BIAS;
         S_BIAS: begin
            mac_ctrl.bias = 1'b1;
            state_in = S_ACT;
         end
         S_ACT: begin
            act_we = 1'b1;
            if (layer_ff == last_ff) begin
               act_wdata = 16'(sig_s);
               if (node_ff == 3'd0) conf_in = sig_s;
            end
            mac_ctrl.clear = 1'b1;
            src_in = '0;
            if ({1'b0, node_ff} == size - 4'd1) begin
               node_in = '0;
               if (layer_ff == last_ff) state_in = S_DONE;
               else begin
                  layer_in = layer_ff + 2'd1;
                  prev_in  = size;
                  bank_in  = !bank_ff;
                  state_in = S_RD;
               end
            end else begin
               node_in  = node_ff + 3'd1;
               state_in = S_RD;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in         = 1'b1;
               rsp_in.first_greater = conf_ff > CONF_HALF;
               rsp_in.confidence    = conf_ff;
               rsp_in.correct       = (conf_ff > CONF_HALF) ? (a_ff > b_ff) : (a_ff < b_ff);
               state_in             = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         layer_ff     <= '0;
         last_ff      <= '0;
         node_ff      <= '0;
         src_ff       <= '0;
         prev_ff      <= 4'd2;
         bank_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         layer_ff     <= layer_in;
         last_ff      <= last_in;
         node_ff      <= node_in;
         src_ff       <= src_in;
         prev_ff      <= prev_in;
         bank_ff      <= bank_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      conf_ff <= conf_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A new result is only ever loaded from the final sequencer state.
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff == S_DONE))
      else $error("result loaded outside the done state");

   // The product loop never runs past the previous layer's node count.
   a_src_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MAC) |-> ({1'b0, src_ff} < prev_ff))
      else $error("source index beyond previous layer");

   // The node index stays inside the current layer.
   a_node_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACT) |-> ({1'b0, node_ff} < size))
      else $error("node index beyond layer size");

   // The layer counter never passes the last computed layer.
   a_layer_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (layer_ff <= last_ff))
      else $error("layer index beyond last layer");
endmodule
